@@ sv/lz77_deflate_match_tokenizer_top_assert.svh @@
// assertion macros for the match tokenizer
`ifndef LZ77_DEFLATE_MATCH_TOKENIZER_TOP_ASSERT_SVH
`define LZ77_DEFLATE_MATCH_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LZDMT_ASSERT_IMP(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define LZDMT_ASSERT_NXT(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/lzdmt_pkg.sv @@
// types, constants and symbol coding for the match tokenizer
package lzdmt_pkg;

	localparam int WINDOW_DEPTH = 32768;
	localparam int MAX_MATCH = 258;
	localparam int MIN_MATCH = 3;
	localparam int BUFFER_DEPTH = 65536;
	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int PW = AW + 1;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_EMIT = 2'd2;

	localparam logic [1:0] TOK_LITERAL = 2'd0;
	localparam logic [1:0] TOK_MATCH = 2'd1;
	localparam logic [1:0] TOK_EOB = 2'd2;

	localparam logic [8:0] SYM_EOB = 9'd256;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic [1:0]  token_kind;
		logic [7:0]  literal_value;
		logic [8:0]  match_length;
		logic [15:0] match_distance;
		logic [8:0]  length_symbol;
		logic [4:0]  length_extra;
		logic [2:0]  length_extra_bits;
		logic [4:0]  distance_symbol;
		logic [12:0] distance_extra;
		logic [3:0]  distance_extra_bits;
		logic        token_last;
	} out_t;

	// match token with deflate length and distance codes
	function automatic out_t encode_match(input logic [8:0] len, input logic [15:0] span);
		out_t t;
		logic [7:0] n3;
		logic [14:0] n1;
		logic [3:0] lbl;
		logic [3:0] dbl;
		logic [2:0] lb;
		logic [3:0] db;
		t = '0;
		n3 = 8'(len - 9'd3);
		n1 = 15'(span - 16'd1);
		lbl = '0;
		for (int k = 0; k < 8; k++) begin
			if (n3[k]) lbl = 4'(k + 1);
		end
		dbl = '0;
		for (int k = 0; k < 15; k++) begin
			if (n1[k]) dbl = 4'(k + 1);
		end
		t.token_kind = TOK_MATCH;
		t.match_length = len;
		t.match_distance = span;
		if (len <= 9'd10) begin
			t.length_symbol = 9'd254 + len;
		end else if (len == 9'(MAX_MATCH)) begin
			t.length_symbol = 9'd285;
		end else begin
			lb = 3'(lbl - 4'd3);
			t.length_extra_bits = lb;
			t.length_extra = 5'(n3 & ((8'd1 << lb) - 8'd1));
			t.length_symbol = 9'd257 + {4'd0, lb, 2'd0} + 9'(n3 >> lb);
		end
		if (span <= 16'd4) begin
			t.distance_symbol = 5'(n1);
		end else begin
			db = dbl - 4'd2;
			t.distance_extra_bits = db;
			t.distance_extra = 13'(n1 & ((15'd1 << db) - 15'd1));
			t.distance_symbol = {db, 1'b0} + 5'(n1 >> db);
		end
		return t;
	endfunction

endpackage

@@ sv/lz77_deflate_match_tokenizer_top.sv @@
// greedy lz77 tokenizer with deflate symbol coding over a 64k byte store
//
// Requests are loaded into a 64K x 8 byte store (one synchronous memory, one write port, two
// read ports, registered reads). Clear and append requests are handled while idle. An emit
// request scans every candidate start in the 32K window before the current position, oldest
// first, comparing one byte pair per memory read: each compared byte is read, then compared,
// and each candidate is closed after a mismatch or when the length limit stops it. The search
// ends early on a 258-byte match or once no remaining candidate could beat the best length.
// A literal needs one extra read, a stalled output adds its stall. The finished token sits in
// an output register; clear and append requests are accepted while it waits, but a new
// request is not taken while a search is running.
`include "lz77_deflate_match_tokenizer_top_assert.svh"
module lz77_deflate_match_tokenizer_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  lzdmt_pkg::in_t  in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output lzdmt_pkg::out_t out_data
);
	import lzdmt_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_CHK  = 7'b0000010,
		ST_CMP  = 7'b0000100,
		ST_NEXT = 7'b0001000,
		ST_DONE = 7'b0010000,
		ST_LIT  = 7'b0100000,
		ST_EMIT = 7'b1000000
	} state_t;

	state_t state_q;
	logic [PW-1:0] loaded_q, pos_q, cand_q;
	logic [8:0] len_q, best_q;
	logic [PW-1:0] best_start_q;
	out_t tok_q, out_q;
	logic out_valid_q;

	// byte store
	logic [7:0] mem [BUFFER_DEPTH];
	logic [7:0] rd_a_q, rd_b_q;
	logic rd_en;
	logic [AW-1:0] addr_a, addr_b;

	logic accept;
	logic chk_ok;
	logic [PW-1:0] cand_n;
	logic [8:0] best_n;
	logic [PW-1:0] win_start;
	logic out_free;
	out_t eob_tok, lit_tok;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// window start for the current position
	assign win_start = (pos_q < PW'(WINDOW_DEPTH)) ? '0 : pos_q - PW'(WINDOW_DEPTH);

	// candidate may extend by one more byte
	assign chk_ok = ({8'd0, len_q} < (pos_q - cand_q))
		&& (({1'b0, pos_q} + (PW+1)'(len_q)) < {1'b0, loaded_q})
		&& (len_q < 9'(MAX_MATCH));

	assign best_n = (len_q > best_q) ? len_q : best_q;
	assign cand_n = cand_q + PW'(1);

	// end-of-block and literal tokens
	always_comb begin
		eob_tok = '0;
		eob_tok.token_kind = TOK_EOB;
		eob_tok.length_symbol = SYM_EOB;
		eob_tok.token_last = 1'b1;
		lit_tok = '0;
		lit_tok.token_kind = TOK_LITERAL;
		lit_tok.literal_value = rd_b_q;
	end

	always_comb begin
		rd_en = 1'b0;
		addr_a = AW'(cand_q + PW'(len_q));
		addr_b = AW'(pos_q + PW'(len_q));
		if (state_q == ST_CHK && chk_ok) rd_en = 1'b1;
		if (state_q == ST_DONE) begin
			rd_en = 1'b1;
			addr_b = AW'(pos_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.command == CMD_APPEND && loaded_q < PW'(BUFFER_DEPTH))
			mem[AW'(loaded_q)] <= in_data.data_byte;
		if (rd_en) begin
			rd_a_q <= mem[addr_a];
			rd_b_q <= mem[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			loaded_q <= '0;
			pos_q <= '0;
			cand_q <= '0;
			len_q <= '0;
			best_q <= '0;
			best_start_q <= '0;
			tok_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_data.command)
							CMD_CLEAR: begin
								loaded_q <= '0;
								pos_q <= '0;
							end
							CMD_APPEND: begin
								if (loaded_q < PW'(BUFFER_DEPTH)) loaded_q <= loaded_q + PW'(1);
							end
							CMD_EMIT: begin
								if (pos_q >= loaded_q) begin
									tok_q <= eob_tok;
									state_q <= ST_EMIT;
								end else begin
									cand_q <= win_start;
									len_q <= '0;
									best_q <= 9'(MIN_MATCH - 1);
									best_start_q <= '0;
									state_q <= (win_start + PW'(MIN_MATCH - 1) < pos_q)
										? ST_CHK : ST_DONE;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CHK: state_q <= chk_ok ? ST_CMP : ST_NEXT;
				ST_CMP: begin
					if (rd_a_q == rd_b_q) begin
						len_q <= len_q + 9'd1;
						state_q <= ST_CHK;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (len_q > best_q) begin
						best_q <= len_q;
						best_start_q <= cand_q;
					end
					len_q <= '0;
					cand_q <= cand_n;
					if (len_q == 9'(MAX_MATCH) || !(cand_n + PW'(best_n) < pos_q))
						state_q <= ST_DONE;
					else
						state_q <= ST_CHK;
				end
				ST_DONE: begin
					if (best_q < 9'(MIN_MATCH)) begin
						state_q <= ST_LIT;
					end else begin
						tok_q <= encode_match(best_q, 16'(pos_q - best_start_q));
						pos_q <= pos_q + PW'(best_q);
						state_q <= ST_EMIT;
					end
				end
				ST_LIT: begin
					tok_q <= lit_tok;
					pos_q <= pos_q + PW'(1);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) out_q <= tok_q;
	end

	`LZDMT_ASSERT_IMP(a_pos_in_range, clk, arst_n, 1'b1, pos_q <= loaded_q, "position past data end")
	`LZDMT_ASSERT_IMP(a_best_bound, clk, arst_n, 1'b1, best_q <= 9'(MAX_MATCH), "match too long")
	`LZDMT_ASSERT_NXT(a_cmp_after_chk, clk, arst_n, state_q == ST_CHK && chk_ok, state_q == ST_CMP, "compare without read")
	`LZDMT_ASSERT_IMP(a_accept_idle, clk, arst_n, in_valid && !in_stall, state_q == ST_IDLE, "request taken while busy")

endmodule

@@ bench/tb_lz77_deflate_match_tokenizer_top.sv @@
// testbench for the lz77 match tokenizer: directed table, random load/emit sequences, token check
`timescale 1ns / 1ps
module tb_lz77_deflate_match_tokenizer_top;
	import lzdmt_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// cycles with nothing accepted on either side before the run is abandoned
	localparam int IDLE_LIMIT = 400000;
	// drain time after the last token
	localparam int DRAIN_CYCLES = 2000;

	typedef struct {
		in_t  req;
		bit   typed;
		out_t want;
	} table_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t  in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;

	// shadow of the block: byte store, data end and tokenizing position
	logic [7:0] shadow_bytes [0:BUFFER_DEPTH-1];
	int         shadow_loaded;
	int         shadow_cursor;

	out_t       pending_tokens[$];
	int         errors = 0;
	int         sender_idle_pct;
	int         receiver_stall_pct;
	int         requests_sent;
	int         tokens_checked = 0;
	int         match_tokens = 0;
	int         idle_cycles;

	lz77_deflate_match_tokenizer_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// bit length of a positive value, index of the top set bit plus one
	function automatic int msb_count(input int v);
		int n;
		n = 0;
		while (v != 0) begin
			n++;
			v = v >> 1;
		end
		return n;
	endfunction

	// greedy token for the current position, with deflate length/distance codes
	function automatic out_t next_token();
		out_t t;
		int   first;
		int   best_len;
		int   best_start;
		int   run;
		int   back_dist;
		int   n;
		int   nb;
		t = '0;
		if (shadow_cursor >= shadow_loaded) begin
			t.token_kind = TOK_EOB;
			t.length_symbol = SYM_EOB;
			t.token_last = 1'b1;
			return t;
		end
		first = (shadow_cursor < WINDOW_DEPTH) ? 0 : shadow_cursor - WINDOW_DEPTH;
		best_len = MIN_MATCH - 1;
		best_start = 0;
		for (int s = first; s + best_len < shadow_cursor; s++) begin
			run = 0;
			while (run < shadow_cursor - s && shadow_cursor + run < shadow_loaded
					&& run < MAX_MATCH
					&& shadow_bytes[s + run] == shadow_bytes[shadow_cursor + run])
				run++;
			if (run > best_len) begin
				best_len = run;
				best_start = s;
				if (run == MAX_MATCH) break;
			end
		end
		if (best_len < MIN_MATCH) begin
			t.token_kind = TOK_LITERAL;
			t.literal_value = shadow_bytes[shadow_cursor];
			shadow_cursor++;
			return t;
		end
		back_dist = shadow_cursor - best_start;
		t.token_kind = TOK_MATCH;
		t.match_length = best_len[8:0];
		t.match_distance = back_dist[15:0];
		// short lengths map straight onto a symbol, the longest has its own
		if (best_len <= 10) begin
			t.length_symbol = 9'(254 + best_len);
		end else if (best_len == MAX_MATCH) begin
			t.length_symbol = 9'd285;
		end else begin
			n = best_len - 3;
			nb = msb_count(n) - 3;
			t.length_extra_bits = nb[2:0];
			t.length_extra = 5'(n & ((1 << nb) - 1));
			t.length_symbol = 9'(257 + 4 * nb + (n >> nb));
		end
		if (back_dist <= 4) begin
			t.distance_symbol = 5'(back_dist - 1);
		end else begin
			n = back_dist - 1;
			nb = msb_count(n) - 2;
			t.distance_extra_bits = nb[3:0];
			t.distance_extra = 13'(n & ((1 << nb) - 1));
			t.distance_symbol = 5'(2 * nb + (n >> nb));
		end
		shadow_cursor += best_len;
		return t;
	endfunction

	// apply one accepted request to the shadow, returns 1 when a token is due
	function automatic bit apply_request(input in_t r, output out_t t);
		t = '0;
		case (r.command)
			CMD_CLEAR: begin
				shadow_loaded = 0;
				shadow_cursor = 0;
			end
			CMD_APPEND: begin
				if (shadow_loaded < BUFFER_DEPTH) begin
					shadow_bytes[shadow_loaded] = r.data_byte;
					shadow_loaded++;
				end
			end
			CMD_EMIT: begin
				t = next_token();
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	// one request through the handshake; a typed row overrides the shadow's token
	task automatic send_request(input in_t r, input bit typed, input out_t want);
		out_t t;
		bit   due;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		due = apply_request(r, t);
		if (due) pending_tokens.push_back(typed ? want : t);
		if (r.command != CMD_UNUSED) requests_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send(input logic [1:0] cmd, input logic [7:0] b);
		in_t r;
		r.command = cmd;
		r.data_byte = b;
		send_request(r, 1'b0, '0);
	endtask

	// let every expected token come back, holding the sender off meanwhile
	task automatic wait_drained();
		while (pending_tokens.size() != 0) @(negedge clk);
	endtask

	// one well-formed sequence: clear, load, tokenize to end of block
	task automatic run_sequence(input int style, input int nbytes);
		logic [7:0] b;
		int         guard;
		send(CMD_CLEAR, 8'($urandom));
		for (int k = 0; k < nbytes; k++) begin
			case (style)
				0: b = 8'($urandom);
				1: b = 8'($urandom_range(3));
				2: b = 8'(8'h40 + k % 5);
				default: b = 8'h5A;
			endcase
			send(CMD_APPEND, b);
		end
		guard = 0;
		while (shadow_cursor < shadow_loaded && guard < 400) begin
			send(CMD_EMIT, 8'($urandom));
			guard++;
			// data appended after tokens went out extends the end
			if ($urandom_range(9) == 0) send(CMD_APPEND, 8'($urandom_range(3)));
			// ignored command value as noise
			if ($urandom_range(19) == 0) send(CMD_UNUSED, 8'($urandom));
		end
		send(CMD_EMIT, 8'($urandom));
		if ($urandom_range(1)) send(CMD_EMIT, 8'($urandom));
	endtask

	// receiver: random stall at the falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// token check against the oldest expectation
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tokens.size() == 0) begin
				$error("token with nothing expected: kind %0d", out_data.token_kind);
				errors++;
			end else begin
				want = pending_tokens.pop_front();
				tokens_checked++;
				if (want.token_kind == TOK_MATCH) match_tokens++;
				if (out_data.token_kind != want.token_kind) begin
					$error("token_kind exp %0d got %0d", want.token_kind,
						out_data.token_kind);
					errors++;
				end
				if (out_data.literal_value != want.literal_value) begin
					$error("literal_value exp %0d got %0d", want.literal_value,
						out_data.literal_value);
					errors++;
				end
				if (out_data.match_length != want.match_length) begin
					$error("match_length exp %0d got %0d", want.match_length,
						out_data.match_length);
					errors++;
				end
				if (out_data.match_distance != want.match_distance) begin
					$error("match_distance exp %0d got %0d", want.match_distance,
						out_data.match_distance);
					errors++;
				end
				if (out_data.length_symbol != want.length_symbol) begin
					$error("length_symbol exp %0d got %0d", want.length_symbol,
						out_data.length_symbol);
					errors++;
				end
				if (out_data.length_extra != want.length_extra) begin
					$error("length_extra exp %0d got %0d", want.length_extra,
						out_data.length_extra);
					errors++;
				end
				if (out_data.length_extra_bits != want.length_extra_bits) begin
					$error("length_extra_bits exp %0d got %0d", want.length_extra_bits,
						out_data.length_extra_bits);
					errors++;
				end
				if (out_data.distance_symbol != want.distance_symbol) begin
					$error("distance_symbol exp %0d got %0d", want.distance_symbol,
						out_data.distance_symbol);
					errors++;
				end
				if (out_data.distance_extra != want.distance_extra) begin
					$error("distance_extra exp %0d got %0d", want.distance_extra,
						out_data.distance_extra);
					errors++;
				end
				if (out_data.distance_extra_bits != want.distance_extra_bits) begin
					$error("distance_extra_bits exp %0d got %0d",
						want.distance_extra_bits, out_data.distance_extra_bits);
					errors++;
				end
				if (out_data.token_last != want.token_last) begin
					$error("token_last exp %0d got %0d", want.token_last,
						out_data.token_last);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles in a row with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("lz77_deflate_match_tokenizer_top: mismatch");
				$finish;
			end
		end
	end

	initial begin
		table_row_t rows[$];
		table_row_t row;
		out_t       eob;
		out_t       lit;
		eob = '0;
		eob.token_kind = TOK_EOB;
		eob.length_symbol = SYM_EOB;
		eob.token_last = 1'b1;

		// directed rows: typed where the token is obvious, shadow otherwise
		row.typed = 1'b1; row.want = eob;
		row.req = '{CMD_EMIT, 8'h00}; rows.push_back(row);       // emit on empty store
		row.typed = 1'b0; row.want = '0;
		row.req = '{CMD_APPEND, 8'h00}; rows.push_back(row);
		row.req = '{CMD_APPEND, 8'hFF}; rows.push_back(row);
		row.typed = 1'b1; lit = '0; lit.literal_value = 8'h00; row.want = lit;
		row.req = '{CMD_EMIT, 8'hFF}; rows.push_back(row);       // first byte is a literal
		row.typed = 1'b1; lit.literal_value = 8'hFF; row.want = lit;
		row.req = '{CMD_EMIT, 8'h00}; rows.push_back(row);
		row.typed = 1'b1; row.want = eob;
		row.req = '{CMD_EMIT, 8'h00}; rows.push_back(row);       // end of block
		row.req = '{CMD_EMIT, 8'hAA}; rows.push_back(row);       // and again after end
		row.typed = 1'b0; row.want = '0;
		row.req = '{CMD_UNUSED, 8'h55}; rows.push_back(row);     // ignored command
		// abcabcabc after the two bytes: literals then a length-3 match
		for (int k = 0; k < 9; k++) begin
			row.req = '{CMD_APPEND, 8'(8'h61 + k % 3)};
			rows.push_back(row);
		end
		for (int k = 0; k < 4; k++) begin
			row.req = '{CMD_EMIT, 8'h00};
			rows.push_back(row);
		end
		row.req = '{CMD_CLEAR, 8'hFF}; rows.push_back(row);
		row.typed = 1'b1; row.want = eob;
		row.req = '{CMD_EMIT, 8'h00}; rows.push_back(row);       // clear leaves nothing

		in_valid = 1'b0;
		in_data = '0;
		requests_sent = 0;
		shadow_loaded = 0;
		shadow_cursor = 0;
		sender_idle_pct = 12;
		receiver_stall_pct = 54;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].want);

		// run of one byte: non-overlapping matches that grow along the run
		run_sequence(3, 16);

		// pressure: sender holds off until every token is back
		wait_drained();

		// random sequences under three idling schemes
		for (int ph = 0; ph < 3; ph++) begin
			sender_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 54 : 0;
			receiver_stall_pct = (ph == 0) ? 54 : (ph == 1) ? 12 : 0;
			repeat (2) run_sequence($urandom_range(2), $urandom_range(1, 6));
		end

		wait_drained();
		send(CMD_CLEAR, 8'h00);
		send(CMD_EMIT, 8'h00);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests (directed table, a run of one repeated byte,",
			requests_sent);
		$display("random load and tokenize sequences), %0d tokens checked, %0d matches",
			tokens_checked, match_tokens);
		if (errors == 0 && pending_tokens.size() == 0) begin
			$display("lz77_deflate_match_tokenizer_top: match");
		end else begin
			$display("lz77_deflate_match_tokenizer_top: mismatch");
		end
		$finish;
	end

endmodule
